// ===== hdl/hll_pkg.sv =====
// shared types and constants for the hyperloglog sketch unit
// no dependencies

package hll_pkg;

  // wide datapath for the bucket sum and the estimate arithmetic
  localparam int unsigned WW = 128;
  localparam int unsigned EST_W = 40;
  localparam int unsigned P_MIN = 4;
  localparam int unsigned P_LIMIT = 16;
  localparam int unsigned LN_ITERS = 34;
  localparam int unsigned DIV_BITS = 32;

  localparam logic [3:0] PRECISION_RST = 4'd14;
  localparam logic [5:0] RANK_MAX = 6'd61;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic [EST_W-1:0] EST_MAX = '1;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_MERGE = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_EST   = 3'd3,
    MODE_READ  = 3'd4,
    MODE_WRITE = 3'd5
  } mode_e;

  // alpha in Q32, rounded to nearest, one entry per bucket-count exponent
  localparam logic [63:0] AD7  = (64'd10000 << 7)  + 64'd10790;
  localparam logic [63:0] AD8  = (64'd10000 << 8)  + 64'd10790;
  localparam logic [63:0] AD9  = (64'd10000 << 9)  + 64'd10790;
  localparam logic [63:0] AD10 = (64'd10000 << 10) + 64'd10790;
  localparam logic [63:0] AD11 = (64'd10000 << 11) + 64'd10790;
  localparam logic [63:0] AD12 = (64'd10000 << 12) + 64'd10790;
  localparam logic [63:0] AD13 = (64'd10000 << 13) + 64'd10790;
  localparam logic [63:0] AD14 = (64'd10000 << 14) + 64'd10790;
  localparam logic [63:0] AD15 = (64'd10000 << 15) + 64'd10790;
  localparam logic [63:0] AD16 = (64'd10000 << 16) + 64'd10790;

  localparam logic [63:0] AQ4  = ((64'd673 << 32) + 64'd500) / 64'd1000;
  localparam logic [63:0] AQ5  = ((64'd697 << 32) + 64'd500) / 64'd1000;
  localparam logic [63:0] AQ6  = ((64'd709 << 32) + 64'd500) / 64'd1000;
  localparam logic [63:0] AQ7  = ((64'd7213 << 39) + (AD7 >> 1)) / AD7;
  localparam logic [63:0] AQ8  = ((64'd7213 << 40) + (AD8 >> 1)) / AD8;
  localparam logic [63:0] AQ9  = ((64'd7213 << 41) + (AD9 >> 1)) / AD9;
  localparam logic [63:0] AQ10 = ((64'd7213 << 42) + (AD10 >> 1)) / AD10;
  localparam logic [63:0] AQ11 = ((64'd7213 << 43) + (AD11 >> 1)) / AD11;
  localparam logic [63:0] AQ12 = ((64'd7213 << 44) + (AD12 >> 1)) / AD12;
  localparam logic [63:0] AQ13 = ((64'd7213 << 45) + (AD13 >> 1)) / AD13;
  localparam logic [63:0] AQ14 = ((64'd7213 << 46) + (AD14 >> 1)) / AD14;
  localparam logic [63:0] AQ15 = ((64'd7213 << 47) + (AD15 >> 1)) / AD15;
  localparam logic [63:0] AQ16 = ((64'd7213 << 48) + (AD16 >> 1)) / AD16;

  localparam logic [31:0] ALPHA_Q [P_MIN:P_LIMIT] = '{
    AQ4[31:0], AQ5[31:0], AQ6[31:0], AQ7[31:0], AQ8[31:0], AQ9[31:0], AQ10[31:0],
    AQ11[31:0], AQ12[31:0], AQ13[31:0], AQ14[31:0], AQ15[31:0], AQ16[31:0]
  };

endpackage

// ===== hdl/hyperloglog_sketch_unit.sv =====
// hyperloglog sketch: rank store, sequencer and shared estimate datapath
// depends on hll_pkg and hll_ram
// add scans one leading zero per cycle; clear sweeps all 2^MAX_PRECISION buckets; estimate is
// the bucket walk, then by range the 32-step divider (mid range), one ln (small range), two ln
// (large range) or a saturated result; each ln shifts to normalise, then runs 34 squarings on
// the shared multiplier. one item at a time, busy high.
// reset: precision 14, then a sweep zeroes the store with busy high.
// results cannot be stalled: done_o marks each for one cycle.

module hyperloglog_sketch_unit import hll_pkg::*; #(
  parameter int unsigned MAX_PRECISION = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic [63:0]        hash_value_i,
  input  logic [13:0]        bucket_index_i,
  input  logic [5:0]         other_rank_i,
  output logic               done_o,
  output logic [EST_W-1:0]   estimate_o,
  output logic               estimate_saturated_o,
  output logic [5:0]         read_rank_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned DEPTH = 1 << MAX_PRECISION;
  localparam int unsigned AW = MAX_PRECISION;
  localparam int unsigned CW = MAX_PRECISION + 1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CLZ, ST_RMW, ST_RDOUT, ST_SUM, ST_SM1, ST_SM2, ST_MID1,
    ST_MID2, ST_SAT, ST_DIV, ST_LN_NORM, ST_LN_SQ, ST_LN_FRAC, ST_LN_K, ST_SMALL_FIN
  } state_e;

  typedef enum logic [1:0] {LN_SMALL, LN_LARGE_A, LN_LARGE_B} ln_ret_e;

  state_e           state_q;
  ln_ret_e          ln_ret_q;
  logic [3:0]       prec_q;
  logic             clr_rep_q;
  logic             done_q;
  logic [EST_W-1:0] est_q;
  logic             sat_q;
  logic [5:0]       rd_q;

  logic [63:0]      h_q;
  logic [6:0]       c_q;
  logic [AW-1:0]    addr_q;
  logic [5:0]       rank_q;
  logic [CW-1:0]    cnt_q;
  logic             vld_q;
  logic [CW-1:0]    zeros_q;
  logic [WW-1:0]    acc_q;
  logic [WW-1:0]    n_q;
  logic [WW-1:0]    t_q;
  logic [WW-1:0]    x_q;
  logic [6:0]       sh_q;
  logic [6:0]       k_q;
  logic [31:0]      f_q;
  logic [33:0]      frac_q;
  logic [5:0]       it_q;
  logic [31:0]      lnf_q;
  logic [EST_W-1:0] lna_q;
  logic [WW-1:0]    rem_q;
  logic [WW-1:0]    ds_q;
  logic [DIV_BITS-1:0] q_q;
  logic [4:0]       div_i_q;

  logic [4:0]       p_eff;
  logic [AW-1:0]    bmask;
  logic [CW-1:0]    mval;
  logic [AW-1:0]    idx_in;
  logic [5:0]       orank_c;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [5:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [5:0]       ram_rdata;
  logic [33:0]      mul_a;
  logic [31:0]      mul_b;
  logic [65:0]      prod;
  logic [32:0]      sq;
  logic [WW-1:0]    d_w;
  logic [5:0]       r_c;
  logic [WW-1:0]    term;
  logic             div_ge;
  logic [DIV_BITS-1:0] q_next;
  logic [EST_W-1:0] ln_val;
  logic [63:0]      small_e;

  always_comb begin
    if (prec_q < 4'(P_MIN)) begin
      p_eff = 5'(P_MIN);
    end else if ({1'b0, prec_q} > 5'(MAX_PRECISION)) begin
      p_eff = 5'(MAX_PRECISION);
    end else begin
      p_eff = {1'b0, prec_q};
    end
  end

  assign mval    = CW'(1) << p_eff;
  assign bmask   = AW'(mval - CW'(1));
  assign idx_in  = AW'(bucket_index_i) & bmask;
  assign orank_c = (other_rank_i > RANK_MAX) ? RANK_MAX : other_rank_i;
  assign d_w     = {acc_q[WW-33:0], 32'b0};

  // bucket term 2^(61-rank)
  assign r_c  = (ram_rdata > RANK_MAX) ? RANK_MAX : ram_rdata;
  assign term = WW'(1) << (RANK_MAX - r_c);

  assign div_ge = (ds_q <= rem_q);
  assign q_next = q_q | (DIV_BITS'(div_ge) << div_i_q);

  // shared multiplier
  always_comb begin
    case (state_q)
      ST_LN_SQ:     begin mul_a = {2'b0, f_q};  mul_b = f_q;     end
      ST_LN_FRAC:   begin mul_a = frac_q;       mul_b = LN2_Q30; end
      ST_LN_K:      begin mul_a = 34'(k_q);     mul_b = LN2_Q32; end
      ST_SMALL_FIN: begin mul_a = 34'(p_eff);   mul_b = LN2_Q32; end
      default:      begin mul_a = '0;           mul_b = '0;      end
    endcase
  end

  assign prod    = 66'(mul_a) * 66'(mul_b);
  assign sq      = prod[63:31];
  assign ln_val  = EST_W'(prod) + EST_W'(lnf_q);
  assign small_e = (((64'(prod) - 64'(lna_q)) << p_eff) + 64'h8000_0000) >> 32;

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = rank_q;
    ram_raddr = addr_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = idx_in;
        ram_waddr = idx_in;
        ram_wdata = orank_c;
        ram_we    = start && (mode_i == MODE_WRITE);
      end
      ST_RMW: begin
        ram_we = (rank_q > ram_rdata);
      end
      ST_SUM: begin
        ram_raddr = cnt_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  hll_ram #(
    .WIDTH (6),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ln_ret_q  <= LN_SMALL;
      prec_q    <= PRECISION_RST;
      clr_rep_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      vld_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (psel && penable && pwrite && (paddr == 3'd0)) begin
        prec_q <= pwdata[3:0];
      end
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q[AW-1:0] == {AW{1'b1}}) begin
            state_q <= ST_IDLE;
            done_q  <= clr_rep_q;
            est_q   <= '0;
            sat_q   <= 1'b0;
            rd_q    <= '0;
          end
        end
        ST_IDLE: begin
          if (start) begin
            est_q <= '0;
            sat_q <= 1'b0;
            rd_q  <= '0;
            case (mode_i)
              MODE_ADD: begin
                h_q     <= hash_value_i;
                addr_q  <= hash_value_i[AW-1:0] & bmask;
                c_q     <= '0;
                state_q <= ST_CLZ;
              end
              MODE_MERGE: begin
                addr_q  <= idx_in;
                rank_q  <= orank_c;
                state_q <= ST_RMW;
              end
              MODE_CLEAR: begin
                cnt_q     <= '0;
                clr_rep_q <= 1'b1;
                state_q   <= ST_CLEAR;
              end
              MODE_EST: begin
                cnt_q   <= '0;
                vld_q   <= 1'b0;
                acc_q   <= '0;
                zeros_q <= '0;
                state_q <= ST_SUM;
              end
              MODE_READ: begin
                state_q <= ST_RDOUT;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_CLZ: begin
          // leading zeros of the hash above the bucket bits, one per cycle
          if (h_q[63] || (c_q == (7'd64 - 7'(p_eff)))) begin
            rank_q  <= 6'(c_q + 7'd1);
            state_q <= ST_RMW;
          end else begin
            h_q <= {h_q[62:0], 1'b0};
            c_q <= c_q + 7'd1;
          end
        end
        ST_RMW: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_RDOUT: begin
          rd_q    <= ram_rdata;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_SUM: begin
          vld_q <= (cnt_q < mval);
          if (cnt_q < mval) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (vld_q) begin
            acc_q <= acc_q + term;
            if (ram_rdata == 6'd0) begin
              zeros_q <= zeros_q + CW'(1);
            end
          end
          if ((cnt_q == mval) && !vld_q) begin
            state_q <= ST_SM1;
          end
        end
        ST_SM1: begin
          n_q     <= WW'(ALPHA_Q[p_eff]) << (7'({p_eff, 1'b0}) + 7'd29);
          t_q     <= acc_q + {acc_q[WW-3:0], 2'b0};
          state_q <= ST_SM2;
        end
        ST_SM2: begin
          // small range: 2N <= 5*S*2^p with empty buckets
          if ((zeros_q != '0) && ({n_q[WW-2:0], 1'b0} <= (t_q << p_eff))) begin
            x_q      <= WW'(zeros_q);
            sh_q     <= '0;
            ln_ret_q <= LN_SMALL;
            state_q  <= ST_LN_NORM;
          end else begin
            state_q <= ST_MID1;
          end
        end
        ST_MID1: begin
          t_q     <= {n_q[WW-6:0], 5'b0} - {n_q[WW-2:0], 1'b0};
          state_q <= ST_MID2;
        end
        ST_MID2: begin
          if (t_q <= d_w) begin
            rem_q   <= {n_q[WW-2:0], 1'b0} + acc_q;
            ds_q    <= d_w;
            q_q     <= '0;
            div_i_q <= 5'(DIV_BITS - 1);
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (d_w <= n_q) begin
            est_q   <= EST_MAX;
            sat_q   <= 1'b1;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            t_q      <= d_w - n_q;
            x_q      <= d_w;
            sh_q     <= '0;
            ln_ret_q <= LN_LARGE_A;
            state_q  <= ST_LN_NORM;
          end
        end
        ST_DIV: begin
          if (div_ge) begin
            rem_q <= rem_q - ds_q;
          end
          ds_q    <= ds_q >> 1;
          q_q     <= q_next;
          div_i_q <= div_i_q - 5'd1;
          if (div_i_q == 5'd0) begin
            est_q   <= EST_W'(q_next);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_LN_NORM: begin
          if (x_q[WW-1]) begin
            f_q     <= x_q[WW-1 -: 32];
            k_q     <= 7'(WW - 1) - sh_q;
            it_q    <= '0;
            frac_q  <= '0;
            state_q <= ST_LN_SQ;
          end else begin
            x_q  <= {x_q[WW-2:0], 1'b0};
            sh_q <= sh_q + 7'd1;
          end
        end
        ST_LN_SQ: begin
          frac_q <= {frac_q[32:0], sq[32]};
          f_q    <= sq[32] ? sq[32:1] : sq[31:0];
          it_q   <= it_q + 6'd1;
          if (it_q == 6'(LN_ITERS - 1)) begin
            state_q <= ST_LN_FRAC;
          end
        end
        ST_LN_FRAC: begin
          lnf_q   <= 32'((prod + 66'h8000_0000) >> 32);
          state_q <= ST_LN_K;
        end
        ST_LN_K: begin
          case (ln_ret_q)
            LN_SMALL: begin
              lna_q   <= ln_val;
              state_q <= ST_SMALL_FIN;
            end
            LN_LARGE_A: begin
              lna_q    <= ln_val;
              x_q      <= t_q;
              sh_q     <= '0;
              ln_ret_q <= LN_LARGE_B;
              state_q  <= ST_LN_NORM;
            end
            default: begin
              est_q   <= (lna_q > ln_val) ? (lna_q - ln_val) : '0;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_SMALL_FIN: begin
          // m * (p*ln2 - ln(zeros)), rounded
          if (64'(lna_q) < 64'(prod)) begin
            est_q <= EST_W'(small_e);
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy                 = (state_q != ST_IDLE);
  assign done_o               = done_q;
  assign estimate_o           = est_q;
  assign estimate_saturated_o = sat_q;
  assign read_rank_o          = rd_q;
  assign prdata               = (paddr == 3'd0) ? {28'b0, prec_q} : 32'b0;
  assign pready               = 1'b1;

endmodule

// ===== hdl/hll_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module hll_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== tb/hll_checker.sv =====
// checker for the hyperloglog sketch unit: predicts every result and compares it
// depends on hll_pkg for the mode encoding, widths and constants

module hll_checker import hll_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  logic [2:0]       mode_i,
  input  logic [63:0]      hash_value_i,
  input  logic [13:0]      bucket_index_i,
  input  logic [5:0]       other_rank_i,
  input  logic             done_o,
  input  logic [EST_W-1:0] estimate_o,
  input  logic             estimate_saturated_o,
  input  logic [5:0]       read_rank_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int unsigned DEPTH = 16384;
  localparam logic [2:0] PRECISION_ADDR = 3'd0;

  typedef struct packed {
    logic [EST_W-1:0] estimate;
    logic             saturated;
    logic [5:0]       rank;
  } sketch_result_t;

  logic [5:0] bucket_ranks [DEPTH];
  logic [3:0] precision_reg;
  sketch_result_t expected_results [$];

  initial fail_count_o = 0;
  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic int unsigned eff_precision();
    if (precision_reg < P_MIN) return P_MIN;
    if (precision_reg > 14) return 14;
    return precision_reg;
  endfunction

  function automatic logic [63:0] alpha_fixed(input int unsigned p);
    logic [63:0] m, num, den;
    m = 64'd1 << p;
    if (p == 4) return ((64'd673 << 32) + 64'd500) / 64'd1000;
    if (p == 5) return ((64'd697 << 32) + 64'd500) / 64'd1000;
    if (p == 6) return ((64'd709 << 32) + 64'd500) / 64'd1000;
    num = (64'd7213 * m) << 32;
    den = 64'd10000 * m + 64'd10790;
    return (num + den / 2) / den;
  endfunction

  // natural log in Q32 via repeated squaring of the mantissa
  function automatic logic [63:0] nat_log_q32(input logic [127:0] x);
    int k;
    logic [63:0] f, frac;
    k = -1;
    frac = '0;
    for (int i = 127; i >= 0; i--) if (x[i] && k < 0) k = i;
    if (k < 0) return '0;
    if (k >= 31) f = 64'(x >> (k - 31));
    else f = 64'(x << (31 - k));
    f &= 64'hFFFF_FFFF;
    for (int i = 0; i < 34; i++) begin
      f = (f * f) >> 31;
      frac = frac << 1;
      if (f >= 64'h1_0000_0000) begin
        f = f >> 1;
        frac[0] = 1'b1;
      end
    end
    return 64'(k) * 64'(LN2_Q32) + ((frac * 64'(LN2_Q30) + 64'h8000_0000) >> 32);
  endfunction

  function automatic sketch_result_t cardinality(input int unsigned p);
    sketch_result_t res;
    logic [127:0] s, n, d, q;
    logic [63:0] m, zeros, lm, lz, a, b, v;
    logic [5:0] r;
    res = '0;
    s = '0;
    zeros = '0;
    m = 64'd1 << p;
    for (int unsigned i = 0; i < m; i++) begin
      r = bucket_ranks[i];
      if (r == 0) zeros++;
      if (r > RANK_MAX) r = RANK_MAX;
      s += 128'd1 << (61 - r);
    end
    n = 128'(alpha_fixed(p)) << (2 * p + 29);
    d = s << 32;
    if (zeros != 0 && (n << 1) <= ((s + (s << 2)) << p)) begin
      // linear counting
      lm = 64'(p) * 64'(LN2_Q32);
      lz = nat_log_q32(128'(zeros));
      if (lz < lm) res.estimate = EST_W'((m * (lm - lz) + 64'h8000_0000) >> 32);
    end else if (((n << 5) - (n << 1)) <= d) begin
      q = ((n << 1) + s) / (s << 1);
      res.estimate = q[EST_W-1:0];
    end else if (d <= n) begin
      res.estimate = EST_MAX;
      res.saturated = 1'b1;
    end else begin
      a = nat_log_q32(d);
      b = nat_log_q32(d - n);
      v = (a > b) ? a - b : 64'd0;
      if (v > 64'(EST_MAX)) begin
        v = 64'(EST_MAX);
        res.saturated = 1'b1;
      end
      res.estimate = v[EST_W-1:0];
    end
    return res;
  endfunction

  function automatic sketch_result_t apply_command(input logic [2:0] mode,
      input logic [63:0] hash, input logic [13:0] index, input logic [5:0] rank_in);
    sketch_result_t res;
    int unsigned p, lz;
    logic [63:0] m, w;
    logic [13:0] idx, b;
    logic [5:0] orank, r;
    res = '0;
    p = eff_precision();
    m = 64'd1 << p;
    idx = index & 14'(m - 1);
    orank = (rank_in > RANK_MAX) ? RANK_MAX : rank_in;
    case (mode)
      MODE_ADD: begin
        b = 14'(hash & (m - 1));
        w = hash >> p;
        lz = 0;
        while (lz < 64 && !w[63 - lz]) lz++;
        r = 6'(lz - p + 1);
        if (r > bucket_ranks[b]) bucket_ranks[b] = r;
      end
      MODE_MERGE: if (orank > bucket_ranks[idx]) bucket_ranks[idx] = orank;
      MODE_CLEAR: for (int i = 0; i < DEPTH; i++) bucket_ranks[i] = '0;
      MODE_EST:   res = cardinality(p);
      MODE_READ:  res.rank = bucket_ranks[idx];
      MODE_WRITE: bucket_ranks[idx] = orank;
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sketch_result_t want;
    if (!rst_ni) begin
      precision_reg <= PRECISION_RST;
      for (int i = 0; i < DEPTH; i++) bucket_ranks[i] = '0;
      expected_results.delete();
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result strobe", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (estimate_o !== want.estimate)
            report_mismatch("estimate", estimate_o, want.estimate);
          if (estimate_saturated_o !== want.saturated)
            report_mismatch("estimate_saturated", estimate_saturated_o, want.saturated);
          if (read_rank_o !== want.rank)
            report_mismatch("read_rank", read_rank_o, want.rank);
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_command(mode_i, hash_value_i, bucket_index_i,
                                                 other_rank_i));
      if (psel && penable && pwrite && pready && paddr == PRECISION_ADDR)
        precision_reg <= pwdata[3:0];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for hyperloglog_sketch_unit: clock, reset, stimulus and verdict
// depends on hll_pkg, hll_checker and the unit itself

module tb_top;
  import hll_pkg::*;

  localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
  localparam logic [2:0] PRECISION_ADDR = 3'd0;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] mode_i = '0;
  logic [63:0] hash_value_i = '0;
  logic [13:0] bucket_index_i = '0;
  logic [5:0] other_rank_i = '0;
  logic done_o;
  logic [EST_W-1:0] estimate_o;
  logic estimate_saturated_o;
  logic [5:0] read_rank_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int idle_pct;
  int unsigned cur_p;
  int commands_sent, estimates_sent, precisions_seen;
  int quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hyperloglog_sketch_unit DUT (.*);

  hll_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .hash_value_i, .bucket_index_i,
    .other_rank_i, .done_o, .estimate_o, .estimate_saturated_o, .read_rank_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic set_precision(input logic [3:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PRECISION_ADDR;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_p = (value < 4) ? 4 : (value > 14) ? 14 : value;
    precisions_seen++;
  endtask

  // stop issuing, then wait until every transfer has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send(input logic [2:0] mode, input logic [63:0] hash,
                      input logic [13:0] index, input logic [5:0] rank_in);
    start <= 1'b1;
    mode_i <= mode;
    hash_value_i <= hash;
    bucket_index_i <= index;
    other_rank_i <= rank_in;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    commands_sent++;
    if (mode == MODE_EST) estimates_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] random_hash();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return w;
      default: return (w >> $urandom_range(0, 63)) | 64'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic logic [5:0] random_rank();
    if ($urandom_range(3) == 0) return 6'($urandom_range(50, 63));
    return 6'($urandom_range(0, 20));
  endfunction

  task automatic random_command();
    int pick;
    int est_w;
    est_w = (cur_p >= 12) ? 1 : 4;
    pick = $urandom_range(0, 999);
    if (pick < est_w * 10) send(MODE_EST, random_hash(), 14'($urandom), random_rank());
    else if (pick < est_w * 10 + est_w * 2)
      send(MODE_CLEAR, random_hash(), 14'($urandom), random_rank());
    else if (pick < 420) send(MODE_ADD, random_hash(), 14'($urandom), 6'($urandom));
    else if (pick < 600) send(MODE_MERGE, random_hash(), 14'($urandom), random_rank());
    else if (pick < 760) send(MODE_READ, random_hash(), 14'($urandom), 6'($urandom));
    else if (pick < 960) send(MODE_WRITE, random_hash(), 14'($urandom), random_rank());
    else send($urandom_range(0, 1) ? MODE_UNDEF_LO : MODE_UNDEF_HI, random_hash(),
              14'($urandom), 6'($urandom));
  endtask

  initial begin
    logic [3:0] phase_prec [8] = '{4'd5, 4'd7, 4'd0, 4'd15, 4'd6, 4'd9, 4'd4, 4'd11};
    idle_pct = 0;
    cur_p = 14;
    commands_sent = 0;
    estimates_sent = 0;
    precisions_seen = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty estimate at reset precision, then the small-store extremes
    send(MODE_EST, '0, '0, '0);
    wait_drained();
    set_precision(4'd4);
    send(MODE_EST, '0, '0, '0);
    send(MODE_ADD, '0, '0, '0);
    send(MODE_ADD, '1, '1, '1);
    send(MODE_READ, '0, 14'd0, '0);
    send(MODE_READ, '0, 14'h3FFF, '0);
    send(MODE_MERGE, '0, 14'd3, 6'd63);
    send(MODE_READ, '0, 14'd3, '0);
    send(MODE_WRITE, '0, 14'd5, 6'd0);
    send(MODE_UNDEF_LO, '1, '1, '1);
    send(MODE_UNDEF_HI, '1, '1, '1);
    send(MODE_EST, '0, '0, '0);
    // saturation: every bucket at the top rank
    for (int i = 0; i < 16; i++) send(MODE_WRITE, '0, 14'(i), 6'd63);
    send(MODE_EST, '0, '0, '0);
    // large range correction
    for (int i = 0; i < 16; i++) send(MODE_MERGE, '0, 14'(i), 6'd28);
    for (int i = 0; i < 16; i++) send(MODE_WRITE, '0, 14'(i), 6'd28);
    send(MODE_EST, '0, '0, '0);
    send(MODE_CLEAR, '0, '0, '0);
    send(MODE_EST, '0, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      set_precision(phase_prec[ph]);
      case (ph % 4)
        1: idle_pct = 45;
        3: idle_pct = 22;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < 100; i++) random_command();
    end
    // largest store, kept short since estimate and clear walk every bucket
    wait_drained();
    set_precision(4'd14);
    for (int i = 0; i < 40; i++) random_command();
    send(MODE_EST, '0, '0, '0);
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("sent %0d commands, %0d of them estimates, over %0d precision settings",
             commands_sent, estimates_sent, precisions_seen);
    $display("%0d mismatches reported", fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
